### rtl/core/stick_radial_deadzone_core_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef STICK_RADIAL_DEADZONE_CORE_MACROS_SVH
`define STICK_RADIAL_DEADZONE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SRDZ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define SRDZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/srdz_pkg.sv
// constants for the radial deadzone pipeline
// no dependencies
package srdz_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int DATA_W    = 16;
  localparam int CFG_W     = 14;
  localparam int LEN2_W    = 2 * DATA_W;
  localparam int MAG_W     = DATA_W;
  localparam int SQ_STEPS  = LEN2_W / 2;
  localparam int THR_W     = 2 * FRAC_BITS + 1;
  localparam int S_W       = FRAC_BITS + 1;
  localparam int NUM_S_W   = 2 * FRAC_BITS + 1;
  localparam int NUM_O_W   = DATA_W + S_W + 1;

  // epsilon 0.0001 in squared units, rounded
  localparam longint EPS2 = ((longint'(1) << (2 * FRAC_BITS)) + 5000) / 10000;

  localparam logic [CFG_W-1:0] DZ_RESET  = CFG_W'(ONE / 4);
  localparam logic [THR_W-1:0] THR_RESET =
    THR_W'((longint'(ONE / 4) * longint'(ONE / 4)) + EPS2);
  localparam logic [MAG_W-1:0] LIM = MAG_W'((ONE < 32767) ? ONE : 32767);

endpackage

### rtl/core/srdz_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on nothing but its parameters
module srdz_div #(
  parameter int NUM_W  = 29,
  parameter int DEN_W  = 15,
  parameter int QUO_W  = 15,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int TW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic              vld_q  [QUO_W];
  logic [NUM_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  quo_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    localparam int K = QUO_W - 1 - i;
    logic              vld_in;
    logic [NUM_W-1:0]  rem_in;
    logic [QUO_W-1:0]  quo_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [TW-1:0]     shifted;
    logic              fits;

    if (i == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    // trial subtract of the shifted divisor
    assign shifted = TW'(den_in) << K;
    assign fits    = TW'(rem_in) >= shifted;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (adv_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[i]  <= fits ? NUM_W'(TW'(rem_in) - shifted) : rem_in;
        quo_q[i]  <= fits ? (quo_in | (QUO_W'(1) << K)) : quo_in;
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[QUO_W-1];
  assign quo_o  = quo_q[QUO_W-1];
  assign side_o = side_q[QUO_W-1];

endmodule

### rtl/core/stick_radial_deadzone_core.sv
// Scaled radial deadzone for a two-axis stick in signed Q2.14. Samples inside the
// deadzone come out as zero with tuser set; others are clamped to unit length, have
// the radius removed and are stretched back to full range, direction kept. The
// pipeline takes one request per clock while the output is not held. Its path holds
// 16 square-root stages, a 15-stage divider for the stretch factor and two 16-stage
// dividers for the components. A held output stalls the whole pipe.
// Uses srdz_pkg and srdz_div.
module stick_radial_deadzone_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,   // stick_x, stick_y
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,   // out_x, out_y
  output logic [0:0]                    m_axis_tuser,   // in_deadzone
  input  logic                          cfg_wr_en_i,
  input  logic [srdz_pkg::CFG_W-1:0]    cfg_wr_data_i
);
  import srdz_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] ax;
    logic [DATA_W-1:0] ay;
    logic              sx;
    logic              sy;
    logic              dzf;
  } meta_t;

  localparam int LAST = SQ_STEPS - 1;

  logic adv;
  logic out_vld_q;
  logic [DATA_W-1:0] out_x_q, out_y_q;
  logic out_dz_q;

  // whole pipe moves unless the output is held
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // deadzone radius register and squared threshold
  logic [CFG_W-1:0]     radius_q;
  logic [FRAC_BITS-1:0] dz;
  logic [THR_W-1:0]     thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= DZ_RESET;
      thr_q    <= THR_RESET;
    end else begin
      if (cfg_wr_en_i) begin
        radius_q <= cfg_wr_data_i;
      end
      thr_q <= THR_W'(dz) * THR_W'(dz) + THR_W'(EPS2);
    end
  end

  assign dz = (radius_q > CFG_W'(ONE - 1)) ? FRAC_BITS'(ONE - 1) : FRAC_BITS'(radius_q);

  // stage 0: magnitudes and signs
  logic signed [DATA_W-1:0] in_x, in_y;
  logic in_vld_q;
  meta_t in_q;

  assign in_x = s_axis_tdata[DATA_W-1:0];
  assign in_y = s_axis_tdata[2*DATA_W-1:DATA_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q.ax  <= in_x[DATA_W-1] ? DATA_W'(-in_x) : DATA_W'(in_x);
      in_q.ay  <= in_y[DATA_W-1] ? DATA_W'(-in_y) : DATA_W'(in_y);
      in_q.sx  <= in_x[DATA_W-1];
      in_q.sy  <= in_y[DATA_W-1];
      in_q.dzf <= 1'b0;
    end
  end

  // stage 1: squared length
  logic [LEN2_W-1:0] sq_ax, sq_ay;
  logic len_vld_q;
  logic [LEN2_W-1:0] len2_q;
  meta_t len_q;

  assign sq_ax = in_q.ax * in_q.ax;
  assign sq_ay = in_q.ay * in_q.ay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_vld_q <= 1'b0;
    end else if (adv) begin
      len_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len2_q <= sq_ax + sq_ay;
      len_q  <= in_q;
    end
  end

  // square root, one result bit per stage
  logic              sq_vld_q [SQ_STEPS];
  logic [LEN2_W-1:0] sq_n_q   [SQ_STEPS];
  logic [LEN2_W:0]   sq_r_q   [SQ_STEPS];
  meta_t             sq_m_q   [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    localparam logic [LEN2_W:0] BIT = (LEN2_W+1)'(1) << (2 * (SQ_STEPS - 1 - i));
    logic              vld_in;
    logic [LEN2_W-1:0] n_in;
    logic [LEN2_W:0]   r_in, trial;
    meta_t             m_in;
    logic              take;

    if (i == 0) begin : g_first
      assign vld_in = len_vld_q;
      assign n_in   = len2_q;
      assign r_in   = '0;
      always_comb begin
        m_in     = len_q;
        m_in.dzf = len2_q <= LEN2_W'(thr_q);
      end
    end else begin : g_next
      assign vld_in = sq_vld_q[i-1];
      assign n_in   = sq_n_q[i-1];
      assign r_in   = sq_r_q[i-1];
      assign m_in   = sq_m_q[i-1];
    end

    assign trial = r_in + BIT;
    assign take  = (LEN2_W+1)'(n_in) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[i] <= 1'b0;
      end else if (adv) begin
        sq_vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_n_q[i] <= take ? LEN2_W'((LEN2_W+1)'(n_in) - trial) : n_in;
        sq_r_q[i] <= take ? ((r_in >> 1) + BIT) : (r_in >> 1);
        sq_m_q[i] <= m_in;
      end
    end
  end

  // round the root to nearest, never zero
  logic [LEN2_W:0]  mag_sum;
  logic [MAG_W-1:0] mag_d;
  logic mg_vld_q;
  logic [MAG_W-1:0] mag_q;
  meta_t mg_q;

  assign mag_sum = sq_r_q[LAST] +
                   (LEN2_W+1)'((LEN2_W+1)'(sq_n_q[LAST]) > sq_r_q[LAST]);
  assign mag_d   = (mag_sum == '0) ? MAG_W'(1) : MAG_W'(mag_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mg_vld_q <= 1'b0;
    end else if (adv) begin
      mg_vld_q <= sq_vld_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q <= mag_d;
      mg_q  <= sq_m_q[LAST];
    end
  end

  // clamp to one, remove the radius, set up the stretch division
  logic [FRAC_BITS:0] mc, diff, den_s;
  logic ns_vld_q;
  logic [NUM_S_W-1:0] num_s_q;
  logic [S_W-1:0]     den_s_q;
  logic [MAG_W-1:0]   ns_mag_q;
  meta_t ns_q;

  assign mc    = (mag_q > MAG_W'(ONE)) ? (FRAC_BITS+1)'(ONE) : (FRAC_BITS+1)'(mag_q);
  assign diff  = (mc > (FRAC_BITS+1)'(dz)) ? (mc - (FRAC_BITS+1)'(dz)) : '0;
  assign den_s = (FRAC_BITS+1)'(ONE) - (FRAC_BITS+1)'(dz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_vld_q <= 1'b0;
    end else if (adv) begin
      ns_vld_q <= mg_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_s_q  <= (NUM_S_W'(diff) << FRAC_BITS) + NUM_S_W'(den_s >> 1);
      den_s_q  <= den_s;
      ns_mag_q <= mag_q;
      ns_q     <= mg_q;
    end
  end

  // stretch factor s
  localparam int SSIDE_W = MAG_W + $bits(meta_t);
  logic              s_vld;
  logic [S_W-1:0]    s_quo;
  logic [SSIDE_W-1:0] s_side;
  logic [MAG_W-1:0]  s_mag;
  meta_t             s_m;

  srdz_div #(
    .NUM_W  (NUM_S_W),
    .DEN_W  (S_W),
    .QUO_W  (S_W),
    .SIDE_W (SSIDE_W)
  ) u_div_s (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (ns_vld_q),
    .num_i  (num_s_q),
    .den_i  (den_s_q),
    .side_i ({ns_mag_q, ns_q}),
    .vld_o  (s_vld),
    .quo_o  (s_quo),
    .side_o (s_side)
  );

  assign {s_mag, s_m} = s_side;

  // component numerators with rounding offset
  logic [NUM_O_W-1:0] prod_x, prod_y;
  logic p_vld_q;
  logic [NUM_O_W-1:0] num_x_q, num_y_q;
  logic [MAG_W-1:0]   p_mag_q;
  meta_t p_q;

  assign prod_x = s_m.ax * s_quo;
  assign prod_y = s_m.ay * s_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (adv) begin
      p_vld_q <= s_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_x_q <= prod_x + NUM_O_W'(s_mag >> 1);
      num_y_q <= prod_y + NUM_O_W'(s_mag >> 1);
      p_mag_q <= s_mag;
      p_q     <= s_m;
    end
  end

  // per-component divide by the length
  logic             ox_vld, oy_vld;
  logic [MAG_W-1:0] qx, qy;
  logic [1:0]       ox_side;
  logic [0:0]       oy_side;

  srdz_div #(
    .NUM_W  (NUM_O_W),
    .DEN_W  (MAG_W),
    .QUO_W  (MAG_W),
    .SIDE_W (2)
  ) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (p_vld_q),
    .num_i  (num_x_q),
    .den_i  (p_mag_q),
    .side_i ({p_q.sx, p_q.dzf}),
    .vld_o  (ox_vld),
    .quo_o  (qx),
    .side_o (ox_side)
  );

  srdz_div #(
    .NUM_W  (NUM_O_W),
    .DEN_W  (MAG_W),
    .QUO_W  (MAG_W),
    .SIDE_W (1)
  ) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (p_vld_q),
    .num_i  (num_y_q),
    .den_i  (p_mag_q),
    .side_i (p_q.sy),
    .vld_o  (oy_vld),
    .quo_o  (qy),
    .side_o (oy_side)
  );

  // saturate, restore sign, zero inside the deadzone
  logic [MAG_W-1:0] sat_x, sat_y;
  logic [DATA_W-1:0] res_x, res_y;

  assign sat_x = (qx > LIM) ? LIM : qx;
  assign sat_y = (qy > LIM) ? LIM : qy;
  assign res_x = ox_side[0] ? '0 : (ox_side[1] ? DATA_W'(-sat_x) : DATA_W'(sat_x));
  assign res_y = ox_side[0] ? '0 : (oy_side[0] ? DATA_W'(-sat_y) : DATA_W'(sat_y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= ox_vld && oy_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_x_q  <= res_x;
      out_y_q  <= res_y;
      out_dz_q <= ox_side[0];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_y_q, out_x_q};
  assign m_axis_tuser  = out_dz_q;

endmodule

### rtl/core/srdz_checker.sv
// port-level checks for the radial deadzone core, bound to the top level
// depends on stick_radial_deadzone_core_macros.svh
`include "stick_radial_deadzone_core_macros.svh"

module srdz_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // a held result keeps its payload
  `SRDZ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // deadzone results are exactly zero
  `SRDZ_ASSERT_NOW(a_dz_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 32'd0)

  // components stay within plus or minus one
  `SRDZ_ASSERT_NOW(a_range, clk_i, rst_ni, m_axis_tvalid, ($signed(m_axis_tdata[15:0]) <= 16'sd16384) && ($signed(m_axis_tdata[15:0]) >= -16'sd16384) && ($signed(m_axis_tdata[31:16]) <= 16'sd16384) && ($signed(m_axis_tdata[31:16]) >= -16'sd16384))

  // an empty output never blocks a new request
  `SRDZ_ASSERT_NOW(a_ready, clk_i, rst_ni, !m_axis_tvalid || m_axis_tready, s_axis_tready)

endmodule

bind stick_radial_deadzone_core srdz_checker u_srdz_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
